// ----- hw/rtl/fmx_pkg.sv -----
package fmx_pkg;

    // Field and register widths.
    localparam int SAMPLE_W  = 16;
    localparam int STEP_W    = 32;
    localparam int GAIN_W    = 15;
    localparam int CFG_IDX_W = 3;

    // Defaults of the top-level parameters.
    localparam int DEF_SINE_ENTRIES = 1024;
    localparam int DEF_PHASE_BITS   = 32;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] CFG_PILOT_STEP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO_STEP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RDS_STEP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MONO_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO_GAIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PILOT_GAIN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RDS_GAIN    = 3'd6;

    // Register values after reset.
    localparam logic [STEP_W-1:0] RST_PILOT_STEP  = 32'd425022451;
    localparam logic [STEP_W-1:0] RST_STEREO_STEP = 32'd850044902;
    localparam logic [STEP_W-1:0] RST_RDS_STEP    = 32'd1275067392;
    localparam logic [GAIN_W-1:0] RST_MONO_GAIN   = 15'd16384;
    localparam logic [GAIN_W-1:0] RST_STEREO_GAIN = 15'd9011;
    localparam logic [GAIN_W-1:0] RST_PILOT_GAIN  = 15'd819;
    localparam logic [GAIN_W-1:0] RST_RDS_GAIN    = 15'd1147;

    // Which carrier addresses the sine table.
    typedef enum logic [1:0] {
        ROM_PILOT,
        ROM_STEREO,
        ROM_RDS
    } t_rom_sel;

    // Operand selection of the shared multiplier.
    typedef enum logic [2:0] {
        MUL_HOLD,
        MUL_MONO,
        MUL_PILOT,
        MUL_DIFF,
        MUL_SGAIN,
        MUL_RDS,
        MUL_RGAIN
    } t_mul_op;

    // Accumulator operation.
    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD_MONO,
        ACC_ADD_PILOT,
        ACC_ADD_STEREO,
        ACC_ADD_RDS
    } t_acc_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MONO,
        ST_PILOT,
        ST_DIFF,
        ST_SGAIN,
        ST_RDS,
        ST_RGAIN,
        ST_SUM,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic     accept;
        t_rom_sel rom_sel;
        t_mul_op  mul_op;
        t_acc_op  acc_op;
        logic     load_out;
    } t_dp_cmd;

endpackage

// ----- hw/rtl/fmx_if.sv -----
interface fmx_in_if import fmx_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic signed [SAMPLE_W-1:0] rds_baseband;

    modport source (output valid, output left_sample, output right_sample,
                    output rds_baseband, input ready);
    modport sink (input valid, input left_sample, input right_sample,
                  input rds_baseband, output ready);
endinterface

interface fmx_out_if import fmx_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] mpx_sample;

    modport source (output valid, output mpx_sample, input ready);
    modport sink (input valid, input mpx_sample, output ready);
endinterface

interface fmx_cfg_if import fmx_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [STEP_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/fmx_ctrl.sv -----
module fmx_ctrl import fmx_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.accept  = 1'b0;
        o_cmd.rom_sel = ROM_RDS;
        o_cmd.mul_op  = MUL_HOLD;
        o_cmd.acc_op  = ACC_HOLD;
        o_cmd.load_out = 1'b0;
        o_in_ready    = 1'b0;
        n_out_valid   = r_out_valid && !i_out_ready;

        unique case (r_state)
            ST_IDLE: begin
                // Nothing is taken while reset is held.
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_MONO;
                end
            end
            ST_MONO: begin
                o_cmd.rom_sel = ROM_PILOT;
                o_cmd.mul_op  = MUL_MONO;
                n_state       = ST_PILOT;
            end
            ST_PILOT: begin
                o_cmd.rom_sel = ROM_STEREO;
                o_cmd.mul_op  = MUL_PILOT;
                o_cmd.acc_op  = ACC_LOAD_MONO;
                n_state       = ST_DIFF;
            end
            ST_DIFF: begin
                o_cmd.mul_op = MUL_DIFF;
                o_cmd.acc_op = ACC_ADD_PILOT;
                n_state      = ST_SGAIN;
            end
            ST_SGAIN: begin
                o_cmd.mul_op = MUL_SGAIN;
                n_state      = ST_RDS;
            end
            ST_RDS: begin
                o_cmd.mul_op = MUL_RDS;
                o_cmd.acc_op = ACC_ADD_STEREO;
                n_state      = ST_RGAIN;
            end
            ST_RGAIN: begin
                o_cmd.mul_op = MUL_RGAIN;
                n_state      = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.acc_op = ACC_ADD_RDS;
                n_state      = ST_OUT;
            end
            ST_OUT: begin
                // Hold here while an earlier result still waits downstream.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- hw/rtl/fmx_datapath.sv -----
module fmx_datapath import fmx_pkg::*; #(
    parameter int SINE_ENTRIES = DEF_SINE_ENTRIES,
    parameter int PHASE_BITS   = DEF_PHASE_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    input  logic signed [SAMPLE_W-1:0] i_left_sample,
    input  logic signed [SAMPLE_W-1:0] i_right_sample,
    input  logic signed [SAMPLE_W-1:0] i_rds_baseband,
    input  logic                       i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [STEP_W-1:0]          i_cfg_data,
    output logic signed [SAMPLE_W-1:0] o_mpx_sample
);

    localparam int IDX_W  = $clog2(SINE_ENTRIES);
    localparam int PROD_W = PHASE_BITS + IDX_W;
    localparam int MA_W   = 33;
    localparam int MB_W   = 16;
    localparam int MP_W   = MA_W + MB_W;
    localparam int ACC_W  = 52;
    localparam int RND_W  = ACC_W - 31;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned TAYLOR_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                   64'd110, 64'd156, 64'd210};

    typedef logic signed [SAMPLE_W-1:0] t_sine_rom [SINE_ENTRIES];

    // Quarter-wave sine in Q30 by Taylor series, scaled to 15 bits.
    function automatic logic [14:0] quarter_sine(input longint unsigned r);
        longint unsigned theta;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned v;
        longint          acc;
        int              n;
        theta = (HALF_PI_Q30 * r) / 64'(SINE_ENTRIES);
        x2    = (theta * theta) >> 30;
        term  = theta;
        acc   = longint'(theta);
        for (n = 1; n <= 7; n++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
            if ((n & 1) == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        v = (64'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return 15'(v);
    endfunction

    function automatic t_sine_rom build_rom();
        t_sine_rom       tab;
        longint unsigned k;
        longint unsigned quad;
        longint unsigned r;
        logic [14:0]     s;
        for (int i = 0; i < SINE_ENTRIES; i++) begin
            k    = 64'(i) * 64'd4;
            quad = (k / 64'(SINE_ENTRIES)) & 64'd3;
            r    = k % 64'(SINE_ENTRIES);
            if (quad[0]) begin
                r = 64'(SINE_ENTRIES) - r;
            end
            s = quarter_sine(r);
            tab[i] = (quad >= 64'd2) ? -$signed({1'b0, s}) : $signed({1'b0, s});
        end
        return tab;
    endfunction

    localparam t_sine_rom SINE_ROM = build_rom();

    // Table index of a phase: floor(phase * entries / 2^PHASE_BITS).
    function automatic logic [IDX_W-1:0] index_of(input logic [PHASE_BITS-1:0] phase);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(phase) * PROD_W'(SINE_ENTRIES);
        return prod[PHASE_BITS +: IDX_W];
    endfunction

    logic [STEP_W-1:0]     r_pilot_step;
    logic [STEP_W-1:0]     r_stereo_step;
    logic [STEP_W-1:0]     r_rds_step;
    logic [GAIN_W-1:0]     r_mono_gain;
    logic [GAIN_W-1:0]     r_stereo_gain;
    logic [GAIN_W-1:0]     r_pilot_gain;
    logic [GAIN_W-1:0]     r_rds_gain;
    logic [PHASE_BITS-1:0] r_pilot_phase;
    logic [PHASE_BITS-1:0] r_stereo_phase;
    logic [PHASE_BITS-1:0] r_rds_phase;

    logic [IDX_W-1:0]           r_pilot_idx;
    logic [IDX_W-1:0]           r_stereo_idx;
    logic [IDX_W-1:0]           r_rds_idx;
    logic signed [SAMPLE_W-1:0] r_left;
    logic signed [SAMPLE_W-1:0] r_right;
    logic signed [SAMPLE_W-1:0] r_rds;
    logic signed [SAMPLE_W-1:0] r_rom_q;
    logic signed [MP_W-1:0]     r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [SAMPLE_W-1:0] r_mpx;

    logic [IDX_W-1:0]           rom_addr;
    logic signed [SAMPLE_W:0]   lr_sum;
    logic signed [SAMPLE_W:0]   lr_diff;
    logic signed [MA_W-1:0]     mul_a;
    logic signed [MB_W-1:0]     mul_b;
    logic signed [ACC_W-1:0]    prod_ext;
    logic signed [ACC_W-1:0]    n_acc;
    logic [ACC_W-1:0]           acc_mag;
    logic [ACC_W-1:0]           rnd_sum;
    logic [RND_W-1:0]           rnd;
    logic [SAMPLE_W-2:0]        sat_mag;
    logic signed [SAMPLE_W-1:0] n_mpx;

    // Configuration registers and phase accumulators.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pilot_step   <= RST_PILOT_STEP;
            r_stereo_step  <= RST_STEREO_STEP;
            r_rds_step     <= RST_RDS_STEP;
            r_mono_gain    <= RST_MONO_GAIN;
            r_stereo_gain  <= RST_STEREO_GAIN;
            r_pilot_gain   <= RST_PILOT_GAIN;
            r_rds_gain     <= RST_RDS_GAIN;
            r_pilot_phase  <= '0;
            r_stereo_phase <= '0;
            r_rds_phase    <= {2'b01, {(PHASE_BITS-2){1'b0}}};
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_PILOT_STEP:  r_pilot_step  <= i_cfg_data;
                    CFG_STEREO_STEP: r_stereo_step <= i_cfg_data;
                    CFG_RDS_STEP:    r_rds_step    <= i_cfg_data;
                    CFG_MONO_GAIN:   r_mono_gain   <= i_cfg_data[GAIN_W-1:0];
                    CFG_STEREO_GAIN: r_stereo_gain <= i_cfg_data[GAIN_W-1:0];
                    CFG_PILOT_GAIN:  r_pilot_gain  <= i_cfg_data[GAIN_W-1:0];
                    CFG_RDS_GAIN:    r_rds_gain    <= i_cfg_data[GAIN_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.accept) begin
                r_pilot_phase  <= r_pilot_phase + PHASE_BITS'(r_pilot_step);
                r_stereo_phase <= r_stereo_phase + PHASE_BITS'(r_stereo_step);
                r_rds_phase    <= r_rds_phase + PHASE_BITS'(r_rds_step);
            end
        end
    end

    // Item registers: samples and table indexes taken from the phases before they advance.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_left       <= i_left_sample;
            r_right      <= i_right_sample;
            r_rds        <= i_rds_baseband;
            r_pilot_idx  <= index_of(r_pilot_phase);
            r_stereo_idx <= index_of(r_stereo_phase);
            r_rds_idx    <= index_of(r_rds_phase);
        end
    end

    always_comb begin
        unique case (i_cmd.rom_sel)
            ROM_PILOT:  rom_addr = r_pilot_idx;
            ROM_STEREO: rom_addr = r_stereo_idx;
            ROM_RDS:    rom_addr = r_rds_idx;
            default:    rom_addr = r_rds_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rom_q <= SINE_ROM[rom_addr];
    end

    assign lr_sum  = {r_left[SAMPLE_W-1], r_left} + {r_right[SAMPLE_W-1], r_right};
    assign lr_diff = {r_left[SAMPLE_W-1], r_left} - {r_right[SAMPLE_W-1], r_right};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.mul_op)
            MUL_MONO: begin
                mul_a = MA_W'(lr_sum);
                mul_b = $signed({1'b0, r_mono_gain});
            end
            MUL_PILOT: begin
                mul_a = MA_W'(r_rom_q);
                mul_b = $signed({1'b0, r_pilot_gain});
            end
            MUL_DIFF: begin
                mul_a = MA_W'(lr_diff);
                mul_b = r_rom_q;
            end
            MUL_SGAIN: begin
                mul_a = r_prod[MA_W-1:0];
                mul_b = $signed({1'b0, r_stereo_gain});
            end
            MUL_RDS: begin
                mul_a = MA_W'(r_rds);
                mul_b = r_rom_q;
            end
            MUL_RGAIN: begin
                mul_a = r_prod[MA_W-1:0];
                mul_b = $signed({1'b0, r_rds_gain});
            end
            MUL_HOLD: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_op != MUL_HOLD) begin
            r_prod <= mul_a * mul_b;
        end
    end

    assign prod_ext = ACC_W'(r_prod);

    always_comb begin
        unique case (i_cmd.acc_op)
            ACC_LOAD_MONO:  n_acc = prod_ext <<< 15;
            ACC_ADD_PILOT:  n_acc = r_acc + (prod_ext <<< 16);
            ACC_ADD_STEREO: n_acc = r_acc + prod_ext;
            ACC_ADD_RDS:    n_acc = r_acc + (prod_ext <<< 1);
            ACC_HOLD:       n_acc = r_acc;
            default:        n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    // Round half away from zero at bit 31 and saturate to +-32767.
    assign acc_mag = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    assign rnd_sum = acc_mag + (ACC_W'(1) << 30);
    assign rnd     = rnd_sum[ACC_W-1:31];
    assign sat_mag = (rnd > RND_W'(32767)) ? '1 : rnd[SAMPLE_W-2:0];
    assign n_mpx   = r_acc[ACC_W-1] ? -$signed({1'b0, sat_mag}) : $signed({1'b0, sat_mag});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_mpx <= n_mpx;
        end
    end

    assign o_mpx_sample = r_mpx;

endmodule

// ----- hw/rtl/fm_stereo_mpx_encoder_unit.sv -----
// A request is taken only in idle, then runs through states mono, pilot, diff, sgain, rds,
// rgain, sum and out, which offers the result once the output is free; one shared 33x16
// multiplier and one sine table read port are stepped through the composite sum's terms.
// Reset (i_rst_n low, synchronous): config registers return to their defaults, the
// pilot and stereo phases clear to zero and the RDS phase starts at a quarter turn.
module fm_stereo_mpx_encoder_unit import fmx_pkg::*; #(
    parameter int SINE_ENTRIES = DEF_SINE_ENTRIES,
    parameter int PHASE_BITS   = DEF_PHASE_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    fmx_in_if.sink    i_in,
    fmx_out_if.source o_out,
    fmx_cfg_if.sink   i_cfg
);

    // The controller sequences each request through the shared multiplier and
    // accumulator; the datapath holds registers, phases, the table and arithmetic.
    t_dp_cmd cmd;
    logic    in_ready;
    logic    out_valid;

    // Register writes are taken whenever reset is released; the user must issue them only
    // while the block is idle, and the block itself does not enforce this.
    assign i_cfg.ready = i_rst_n;

    fmx_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    fmx_datapath #(
        .SINE_ENTRIES (SINE_ENTRIES),
        .PHASE_BITS   (PHASE_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_left_sample  (i_in.left_sample),
        .i_right_sample (i_in.right_sample),
        .i_rds_baseband (i_in.rds_baseband),
        .i_cfg_valid    (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .o_mpx_sample   (o_out.mpx_sample)
    );

    // A new request is taken while a finished result still waits in the output
    // register; the controller holds the next result back until that one leaves.
    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule
